[rtl/cbce_pkg.sv]
// Shared types and constants for the closed Bezier curve evaluator.
package cbce_pkg;

    localparam int MaxPoints = 8;
    localparam int MaxSteps  = 64;
    localparam int PtrW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int TermW     = $clog2(MaxPoints + 2);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_GEN  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FEW   = 2'd3;

    localparam logic [1:0] ADDR_STEPS = 2'd0;
    localparam logic [1:0] ADDR_SIZE  = 2'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    // Binomial coefficient C(n,i), n up to MaxPoints, built as Pascal rows.
    function automatic logic [7:0] binom(input logic [CntW-1:0] n,
                                         input logic [CntW-1:0] i);
        logic [7:0] row [MaxPoints+1];
        for (int j = 0; j <= MaxPoints; j++) begin
            row[j] = (j == 0) ? 8'd1 : 8'd0;
        end
        for (int k = 1; k <= MaxPoints; k++) begin
            if (k <= int'(n)) begin
                for (int j = MaxPoints; j >= 1; j--) begin
                    row[j] = row[j] + row[j-1];
                end
            end
        end
        return row[i];
    endfunction

endpackage

[rtl/cbce_store.sv]
// Control point memory: one write port, one registered read port.
module cbce_store
    import cbce_pkg::*;
(
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [PtrW-1:0] wr_addr,
    input  point_t          wr_data,
    input  logic [PtrW-1:0] rd_addr,
    output point_t          rd_data
);
    point_t mem [MaxPoints];
    point_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule

[rtl/cbce_engine.sv]
// Sample sequencer: power, weight and accumulate steps per curve sample.
module cbce_engine
    import cbce_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [CntW-1:0] n_pts,
    input  logic [6:0]      steps,
    input  logic [15:0]     step_size,
    output logic            busy,
    output logic [PtrW-1:0] rd_addr,
    input  point_t          rd_data,
    output logic            res_valid,
    input  logic            res_ready,
    output point_t          res_point,
    output logic [5:0]      res_index,
    output logic            res_last
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POW   = 5'b00010,
        S_WGT   = 5'b00100,
        S_ACC   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0]  k_reg;
    logic [6:0]  nsteps_reg;
    logic [16:0] t_reg, u_reg;
    logic [16:0] tp_reg [MaxPoints+1];
    logic [16:0] up_reg [MaxPoints+1];
    logic [TermW-1:0] i_reg;
    logic [1:0]  ph_reg;
    logic [22:0] a_reg;
    logic [33:0] prod_reg;
    logic [16:0] w_reg;
    logic signed [41:0] ax_reg, ay_reg, az_reg;
    logic [22:0] tk;
    logic [16:0] tn;
    logic [33:0] pmul;
    logic [16:0] qm;
    logic [TermW-1:0] nmi;
    logic signed [17:0] ws;

    assign busy = (state_reg != S_IDLE);
    // t for the next sample, clamped to 1.0
    assign tk = 23'(k_reg + 6'd1) * 23'(step_size);
    assign tn = (tk > 23'h10000) ? 17'h10000 : 17'(tk);
    assign nmi = TermW'(n_pts) - i_reg;
    assign qm = 17'((pmul + 34'd32768) >> 16);
    assign ws = $signed({1'b0, w_reg});
    assign rd_addr = (i_reg == TermW'(n_pts)) ? '0 : PtrW'(i_reg);

    // One shared multiplier, operands picked by state and phase.
    always_comb begin
        pmul = '0;
        if (state_reg == S_POW) begin
            pmul = ph_reg[0] ? 34'(up_reg[i_reg - TermW'(1)]) * 34'(u_reg)
                             : 34'(tp_reg[i_reg - TermW'(1)]) * 34'(t_reg);
        end else if (state_reg == S_WGT) begin
            pmul = ph_reg[0] ? 34'(a_reg) * 34'(up_reg[nmi])
                             : 34'(binom(n_pts, CntW'(i_reg))) * 34'(tp_reg[i_reg]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_POW;
            S_POW:  if (ph_reg[0] && i_reg == TermW'(n_pts)) state_next = S_WGT;
            S_WGT:  if (ph_reg == 2'd2) state_next = S_ACC;
            S_ACC:  state_next = (i_reg == TermW'(n_pts)) ? S_OUT : S_WGT;
            S_OUT:  if (res_ready) begin
                state_next = (7'(k_reg) + 7'd1 == nsteps_reg) ? S_IDLE : S_POW;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        unique case (state_reg)
            S_IDLE: begin
                k_reg <= '0;
                nsteps_reg <= (steps == 7'd0) ? 7'd1 :
                              (steps > 7'(MaxSteps)) ? 7'(MaxSteps) : steps;
                i_reg <= TermW'(1);
                ph_reg <= '0;
                t_reg <= 17'd0;
                u_reg <= 17'h10000;
                tp_reg[0] <= 17'h10000;
                up_reg[0] <= 17'h10000;
            end
            S_POW: begin
                if (!ph_reg[0]) begin
                    tp_reg[i_reg] <= qm;
                    ph_reg <= 2'd1;
                end else begin
                    up_reg[i_reg] <= qm;
                    ph_reg <= '0;
                    if (i_reg == TermW'(n_pts)) begin
                        i_reg <= '0;
                        ax_reg <= '0;
                        ay_reg <= '0;
                        az_reg <= '0;
                    end else begin
                        i_reg <= i_reg + TermW'(1);
                    end
                end
            end
            S_WGT: begin
                // binom*t^i, then times u^(n-i) and round; store read runs alongside
                unique case (ph_reg)
                    2'd0: begin a_reg <= 23'(pmul); ph_reg <= 2'd1; end
                    2'd1: begin prod_reg <= pmul; ph_reg <= 2'd2; end
                    default: begin
                        w_reg <= 17'((prod_reg + 34'd32768) >> 16);
                        ph_reg <= '0;
                    end
                endcase
            end
            S_ACC: begin
                ax_reg <= ax_reg + 42'(ws * rd_data.x);
                ay_reg <= ay_reg + 42'(ws * rd_data.y);
                az_reg <= az_reg + 42'(ws * rd_data.z);
                i_reg <= i_reg + TermW'(1);
            end
            S_OUT: begin
                if (res_ready) begin
                    k_reg <= k_reg + 6'd1;
                    i_reg <= TermW'(1);
                    t_reg <= tn;
                    u_reg <= 17'h10000 - tn;
                end
            end
            default: ;
        endcase
    end

    function automatic logic [15:0] rsat(input logic signed [41:0] a);
        logic signed [41:0] r;
        r = (a + 42'sd32768) >>> 16;
        if (r > 42'sd32767) return 16'h7fff;
        if (r < -42'sd32768) return 16'h8000;
        return r[15:0];
    endfunction

    assign res_valid = (state_reg == S_OUT);
    assign res_point = '{x: rsat(ax_reg), y: rsat(ay_reg), z: rsat(az_reg)};
    assign res_index = k_reg;
    assign res_last  = (7'(k_reg) + 7'd1 == nsteps_reg);
endmodule

[rtl/closed_bezier_curve_evaluator_top.sv]
// Top level: command channel, APB registers, point stack and result register.
// Usage:
//   s_ channel carries a command (push, pop, generate) and a point; m_ channel
//   returns results. Push and pop give one result with status in the cycle
//   after the command beat.
//   Generate with n points gives curve_steps samples, clamped to 1..64. Each
//   sample runs power steps and, per Bernstein term (n+1 terms), weight steps
//   on the shared multiplier and an accumulate step, then an output step that
//   waits for m_ready.
//   Fewer than two points gives one result with status 3. Command 3 is dropped.
//   One command is handled at a time; s_ready is low while a run is in flight.
//   A result holds on the m_ outputs while m_ready is low; the engine
//   holds until the beat is taken.
//   APB registers: 0x0 curve_steps, 0x4 step_size. Write them only when idle.
//   Reset (aresetn low, synchronous) clears the point count and control state
//   and restores curve_steps 64 and step_size 1024. Point memory is not cleared;
//   only entries below the count are ever used.
module closed_bezier_curve_evaluator_top
    import cbce_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic signed [15:0] s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_curve_x,
    output logic signed [15:0] m_curve_y,
    output logic signed [15:0] m_curve_z,
    output logic [5:0]         m_sample_index,
    output logic               m_last_of_run,
    output logic [1:0]         m_status
);
    logic [6:0]      steps_reg;
    logic [15:0]     size_reg;
    logic [CntW-1:0] count_reg;
    logic            sv_reg;
    logic [1:0]      sst_reg;
    logic            acc, wr_en, eng_start, busy;
    logic [PtrW-1:0] rd_addr;
    point_t          rd_data, e_pt;
    logic            e_valid, e_ready, e_last;
    logic [5:0]      e_idx;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            ADDR_STEPS[0]: prdata = {25'd0, steps_reg};
            default:       prdata = {16'd0, size_reg};
        endcase
    end

    assign s_ready = !busy && !sv_reg;
    assign acc = s_valid && s_ready;
    assign wr_en = acc && s_command == CMD_PUSH && count_reg < CntW'(MaxPoints);
    assign eng_start = acc && s_command == CMD_GEN && count_reg >= CntW'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= 7'd64;
            size_reg  <= 16'd1024;
            count_reg <= '0;
            sv_reg    <= 1'b0;
            sst_reg   <= ST_OK;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == ADDR_SIZE[0]) size_reg <= pwdata[15:0];
                else steps_reg <= pwdata[6:0];
            end
            if (sv_reg && m_ready) sv_reg <= 1'b0;
            if (acc) begin
                unique case (s_command)
                    CMD_PUSH: begin
                        sv_reg <= 1'b1;
                        sst_reg <= (count_reg < CntW'(MaxPoints)) ? ST_OK : ST_FULL;
                        if (count_reg < CntW'(MaxPoints)) count_reg <= count_reg + CntW'(1);
                    end
                    CMD_POP: begin
                        sv_reg <= 1'b1;
                        sst_reg <= (count_reg != '0) ? ST_OK : ST_EMPTY;
                        if (count_reg != '0) count_reg <= count_reg - CntW'(1);
                    end
                    CMD_GEN: begin
                        if (count_reg < CntW'(2)) begin
                            sv_reg <= 1'b1;
                            sst_reg <= ST_FEW;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    cbce_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (PtrW'(count_reg)),
        .wr_data ('{x: s_point_x, y: s_point_y, z: s_point_z}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cbce_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .n_pts     (count_reg),
        .steps     (steps_reg),
        .step_size (size_reg),
        .busy      (busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (e_valid),
        .res_ready (e_ready),
        .res_point (e_pt),
        .res_index (e_idx),
        .res_last  (e_last)
    );

    assign e_ready        = m_ready;
    assign m_valid        = sv_reg || e_valid;
    assign m_curve_x      = sv_reg ? 16'sd0 : e_pt.x;
    assign m_curve_y      = sv_reg ? 16'sd0 : e_pt.y;
    assign m_curve_z      = sv_reg ? 16'sd0 : e_pt.z;
    assign m_sample_index = sv_reg ? 6'd0 : e_idx;
    assign m_last_of_run  = sv_reg ? 1'b1 : e_last;
    assign m_status       = sv_reg ? sst_reg : ST_OK;
endmodule
